[rtl/core/mmn_pkg.sv]
// Shared types and constants for the min-max column normalizer.
// No dependencies; every other file but mmn_ram imports this package.
package mmn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SCALED_W = 16;
  localparam int DIV_STEPS = 16;
  localparam int STEP_W = $clog2(DIV_STEPS);

  // Full scale of the Q1.15 result: 1.0
  localparam logic [SCALED_W-1:0] SCALED_ONE = 16'h8000;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } mmn_state_t;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] numer;
    logic [SAMPLE_W-1:0] denom;
  } mmn_div_ctrl_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SCALED_W-1:0] quot;
  } mmn_div_stat_t;

endpackage

[rtl/core/mmn_if.sv]
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on mmn_pkg for the field widths.
interface mmn_in_if import mmn_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink (input valid, input sample, input last_in, output ready);
endinterface

interface mmn_out_if import mmn_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [SCALED_W-1:0] scaled;
  logic                last_out;

  modport source (output valid, output scaled, output last_out, input ready);
  modport sink (input valid, input scaled, input last_out, output ready);
endinterface

[rtl/core/min_max_normalize_column_unit.sv]
// Top level of the min-max column normalizer: sequencer, buffer and divider.
// Depends on mmn_pkg, mmn_if, mmn_ram and mmn_div.
//
//  channel  dir  handshake     payload
//  in_beat  in   valid/ready   sample (s16), last_in (1)
//  out_beat out  valid/ready   scaled (u16 Q1.15), last_out (1)
//
// A beat marked last starts emission; each result passes through the
// buffer read, operand prep, the divider's 16 steps and its done pulse,
// and output, plus any wait on out_beat.ready; every result goes through
// the one shared restoring divider.
// in_beat.ready is low for the whole emission of a column.
// Reset clears the sequencer, fill count and divider control; the sample
// buffer needs no clearing, since only entries of the current column are read.
// A stall on out_beat holds the result register and the sequencer.
module min_max_normalize_column_unit import mmn_pkg::*; #(
  parameter int COLUMN_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  mmn_in_if.sink     in_beat,
  mmn_out_if.source  out_beat
);

  localparam int CNT_W = $clog2(COLUMN_DEPTH + 1);
  localparam int IDX_W = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;

  mmn_state_t state_r, state_nxt;

  logic [CNT_W-1:0]           fill_cnt_r, fill_cnt_nxt;
  logic [IDX_W-1:0]           rd_idx_r, rd_idx_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SAMPLE_W-1:0]        range_r, range_nxt;
  logic [SCALED_W-1:0]        scaled_r, scaled_nxt;
  logic                       last_r, last_nxt;

  logic                       in_fire;
  logic                       out_fire;
  logic                       store;
  logic [CNT_W-1:0]           cnt_after;
  logic                       is_final;
  logic                       ram_wr_en;
  logic [SAMPLE_W-1:0]        ram_rd_data;
  logic signed [SAMPLE_W:0]   span;
  logic signed [SAMPLE_W:0]   offset;

  mmn_div_ctrl_t div_ctrl;
  mmn_div_stat_t div_stat;

  // Handshake decode and fill bookkeeping.
  assign in_fire   = in_beat.valid && in_beat.ready;
  assign out_fire  = out_beat.valid && out_beat.ready;
  assign store     = fill_cnt_r < CNT_W'(COLUMN_DEPTH);
  assign cnt_after = store ? fill_cnt_r + CNT_W'(1) : fill_cnt_r;
  assign is_final  = (CNT_W'(rd_idx_r) + CNT_W'(1)) == fill_cnt_r;

  // Differences are exact in 17 bits; their values fit 16 unsigned bits.
  assign span   = {max_r[SAMPLE_W-1], max_r} - {min_r[SAMPLE_W-1], min_r};
  assign offset = {ram_rd_data[SAMPLE_W-1], ram_rd_data} - {min_r[SAMPLE_W-1], min_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_beat.last_in && cnt_after != '0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          state_nxt = last_r ? ST_LOAD : ST_READ;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Control outputs per state.
  always_comb begin
    in_beat.ready  = 1'b0;
    out_beat.valid = 1'b0;
    div_ctrl.start = 1'b0;
    div_ctrl.numer = offset[SAMPLE_W-1:0];
    div_ctrl.denom = range_r;
    case (state_r)
      ST_LOAD: in_beat.ready  = 1'b1;
      ST_PREP: div_ctrl.start = 1'b1;
      ST_OUT:  out_beat.valid = 1'b1;
      default: ;
    endcase
  end

  assign ram_wr_en      = in_fire && store;

  // Datapath updates.
  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    rd_idx_nxt   = rd_idx_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    range_nxt    = range_r;
    scaled_nxt   = scaled_r;
    last_nxt     = last_r;

    if (ram_wr_en) begin
      fill_cnt_nxt = cnt_after;
      // First sample of a column seeds both extremes.
      if (fill_cnt_r == '0) begin
        min_nxt = in_beat.sample;
        max_nxt = in_beat.sample;
      end else begin
        if (in_beat.sample < min_r) min_nxt = in_beat.sample;
        if (in_beat.sample > max_r) max_nxt = in_beat.sample;
      end
    end
    if (in_fire && in_beat.last_in) begin
      rd_idx_nxt = '0;
      if (cnt_after == '0) begin
        fill_cnt_nxt = '0;
      end
    end

    if (state_r == ST_READ) begin
      range_nxt = span[SAMPLE_W-1:0];
    end

    // Capture the result; a constant column gives zero.
    if (state_r == ST_DIV && div_stat.done) begin
      scaled_nxt = (range_r == '0) ? '0 : div_stat.quot;
      last_nxt   = is_final;
    end

    // Advance to the next buffered sample, or drop the column at its end.
    if (out_fire) begin
      if (last_r) begin
        fill_cnt_nxt = '0;
      end else begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      fill_cnt_r <= '0;
      min_r      <= '0;
      max_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
    end
    rd_idx_r <= rd_idx_nxt;
    range_r  <= range_nxt;
    scaled_r <= scaled_nxt;
    last_r   <= last_nxt;
  end

  assign out_beat.scaled   = scaled_r;
  assign out_beat.last_out = last_r;

  mmn_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (COLUMN_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_cnt_r[IDX_W-1:0]),
    .wr_data (in_beat.sample),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rd_data)
  );

  mmn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .stat  (div_stat)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CNT_W'(COLUMN_DEPTH))
    else $error("fill count past buffer depth");
  a_scaled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid |-> out_beat.scaled <= SCALED_ONE)
    else $error("scaled result above full scale");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid |-> fill_cnt_r != '0 && CNT_W'(rd_idx_r) < fill_cnt_r)
    else $error("result emitted from empty buffer");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid && !out_beat.ready |=> out_beat.valid && $stable(scaled_r))
    else $error("stalled result changed");
`endif

endmodule

[rtl/core/mmn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                    wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                    rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/mmn_div.sv]
// Iterative restoring divider: one quotient bit per cycle while busy; a start is taken only when idle.
// Computes floor(numer * 2^15 / denom) given numer <= denom; uses mmn_pkg.
module mmn_div import mmn_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  mmn_div_ctrl_t ctrl,
  output mmn_div_stat_t stat
);

  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] den_r, den_nxt;
  logic [SCALED_W-1:0] quo_r, quo_nxt;
  logic                lsb_r, lsb_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SAMPLE_W:0]   trial;
  logic                q_bit;

  always_comb begin
    // Shift the low numerator bit in on the first step, zeros after.
    trial = {rem_r, (cnt_r == '0) ? lsb_r : 1'b0};
    q_bit = (trial >= {1'b0, den_r});
  end

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    lsb_nxt  = lsb_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      rem_nxt = q_bit ? SAMPLE_W'(trial - {1'b0, den_r}) : trial[SAMPLE_W-1:0];
      quo_nxt = {quo_r[SCALED_W-2:0], q_bit};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ctrl.start) begin
      // Upper part of numer * 2^15 seeds the remainder.
      rem_nxt  = {1'b0, ctrl.numer[SAMPLE_W-1:1]};
      lsb_nxt  = ctrl.numer[0];
      den_nxt  = ctrl.denom;
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    lsb_r <= lsb_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quot = quo_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start && !busy_r |=> busy_r && cnt_r == '0)
    else $error("divider did not start");
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == STEP_W'(DIV_STEPS - 1) |=> done_r && !busy_r)
    else $error("divider missed its done pulse");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");
`endif

endmodule

[verif/min_max_normalize_column_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for min_max_normalize_column_unit.
// Depends on mmn_pkg, mmn_if and the RTL; holds its own column predictor.
module min_max_normalize_column_unit_test;
  import mmn_pkg::*;

  localparam int DEPTH         = 64;
  localparam int HALF_PERIOD   = 6;
  localparam int RANDOM_ITEMS  = 400;
  localparam int TAIL_ITEMS    = 40;   // no idling once this few beats are left
  localparam int DRAIN_CYCLES  = 64;   // idle wait after the last result is checked

  // Shape of the values in one random column
  typedef enum int {
    COL_WIDE,    // anywhere in the signed range
    COL_NARROW,  // small spread around a base, so the range is tiny
    COL_FLAT,    // every sample equal, so every result is zero
    COL_RAIL     // mostly the two extremes of the sample field
  } column_mode_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_beat_t;

  typedef struct {
    logic [SCALED_W-1:0] scaled;
    logic                last;
  } scaled_beat_t;

  logic clk;
  logic rst_n;

  mmn_in_if  in_beat ();
  mmn_out_if out_beat ();

  min_max_normalize_column_unit #(
    .COLUMN_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .out_beat (out_beat)
  );

  // Sample beats waiting to be driven, and scaled beats still owed by the block
  sample_beat_t pending_samples[$];
  scaled_beat_t scaled_due_q[$];

  // Predictor copy of the column state
  logic signed [SAMPLE_W-1:0] col_store [DEPTH];
  int unsigned                col_fill;
  logic signed [SAMPLE_W-1:0] col_min;
  logic signed [SAMPLE_W-1:0] col_max;
  bit                         col_overfull;

  // Bookkeeping
  int beats_total;
  int beats_taken;
  int columns_done;
  int overfull_columns;
  int results_checked;
  int fail_count;
  int gap_left;
  int stall_left;
  bit quiet_tail;
  sample_beat_t next_beat;
  scaled_beat_t due;

  // Clock, reset and known values on every block input from time zero
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_beat.valid  = 1'b0;
    in_beat.sample = '0;
    in_beat.last_in = 1'b0;
    out_beat.ready = 1'b0;
    fork
      forever #HALF_PERIOD clk = ~clk;
      begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // Take one accepted sample beat into the column and, when it closes the
  // column, queue the scaled beats the block owes for it. A sample that
  // arrives with the buffer full is dropped but its last mark still counts.
  function automatic void scale_column_beat(logic signed [SAMPLE_W-1:0] x, logic mark);
    int           span;
    int           offs;
    scaled_beat_t r;
    if (col_fill < DEPTH) begin
      col_store[col_fill] = x;
      if (col_fill == 0) begin
        col_min = x;
        col_max = x;
      end else begin
        if (x < col_min) col_min = x;
        if (x > col_max) col_max = x;
      end
      col_fill++;
    end else begin
      col_overfull = 1'b1;
    end
    if (mark) begin
      span = int'(col_max) - int'(col_min);
      for (int i = 0; i < col_fill; i++) begin
        offs     = int'(col_store[i]) - int'(col_min);
        // constant column: span is zero and every result is zero
        r.scaled = (span == 0) ? '0 : SCALED_W'((longint'(offs) * 32768) / span);
        r.last   = (i == col_fill - 1);
        scaled_due_q.insert(scaled_due_q.size(), r);
      end
      col_fill = 0;
      columns_done++;
      if (col_overfull) overfull_columns++;
      col_overfull = 1'b0;
    end
  endfunction

  // Driver: present the next pending beat, hold it until taken, and insert
  // idle bursts of random length in two of every three stretches of 50 taken beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_beat.valid   <= 1'b0;
      in_beat.sample  <= '0;
      in_beat.last_in <= 1'b0;
      gap_left = 0;
    end else begin
      quiet_tail <= (pending_samples.size() < TAIL_ITEMS);
      if (in_beat.valid && in_beat.ready) begin
        scale_column_beat(in_beat.sample, in_beat.last_in);
        beats_taken++;
      end
      if (!in_beat.valid || in_beat.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_beat.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_beat = pending_samples.pop_front();
          in_beat.valid   <= 1'b1;
          in_beat.sample  <= next_beat.sample;
          in_beat.last_in <= next_beat.last;
          // schedule an idle burst after this beat, except in quiet stretches
          if (!quiet_tail && ((beats_taken / 50) % 3 != 2) && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 6);
        end else begin
          in_beat.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each scaled beat against the oldest expectation and
  // stall the result side in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_beat.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_beat.valid && out_beat.ready) begin
        if (scaled_due_q.size() == 0) begin
          $display("%0t: unexpected scaled beat: scaled=%0d last=%0b", $time,
                   out_beat.scaled, out_beat.last_out);
          fail_count++;
        end else begin
          due = scaled_due_q.pop_front();
          if (out_beat.scaled !== due.scaled) begin
            $display("%0t: scaled mismatch: expected %0d, actual %0d", $time,
                     due.scaled, out_beat.scaled);
            fail_count++;
          end
          if (out_beat.last_out !== due.last) begin
            $display("%0t: last_out mismatch: expected %0b, actual %0b", $time,
                     due.last, out_beat.last_out);
            fail_count++;
          end
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_beat.ready <= 1'b0;
      end else if (!quiet_tail && ((results_checked / 40) % 3 != 1) &&
                   $urandom_range(0, 4) == 0) begin
        // start a stall burst of random length here
        stall_left = $urandom_range(0, 5);
        out_beat.ready <= 1'b0;
      end else begin
        out_beat.ready <= 1'b1;
      end
    end
  end

  // Add one beat to the stimulus
  function automatic void push_sample(logic signed [SAMPLE_W-1:0] s, logic mark);
    sample_beat_t b;
    b.sample = s;
    b.last   = mark;
    pending_samples.insert(pending_samples.size(), b);
  endfunction

  // Stimulus, then drain and verdict
  initial begin
    int                         random_items;
    int                         col_len;
    int                         col_idx;
    column_mode_t               mode;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W-1:0] s;

    // Single sample column: constant by definition, result is zero
    push_sample(16'sh8000, 1'b1);
    // Full signed range: results span 0 to 1.0, midpoints at 0.5 and just below it
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'shffff, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    // Alternating bit patterns
    push_sample(16'sh5555, 1'b0);
    push_sample(16'shaaaa, 1'b1);
    // Flat column of a negative value
    push_sample(-16'sd7, 1'b0);
    push_sample(-16'sd7, 1'b0);
    push_sample(-16'sd7, 1'b1);
    // Range of one: results are exactly 0 and 1.0
    push_sample(16'sd100, 1'b0);
    push_sample(16'sd101, 1'b1);
    // First sample sits mid-range; min and max move later
    push_sample(16'sd50, 1'b0);
    push_sample(-16'sd20, 1'b0);
    push_sample(16'sd80, 1'b0);
    push_sample(16'sd10, 1'b1);
    // All positive after a negative-min column: first sample must reload both
    push_sample(16'sd1000, 1'b0);
    push_sample(16'sd1200, 1'b0);
    push_sample(16'sd1100, 1'b1);

    // Random columns: mostly short, now and then one of 63 to 70 samples,
    // with the last mark on the 63rd sample, on the 64th or on a dropped one.
    random_items = 0;
    col_idx      = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (col_idx == 2 || col_idx == 25 || $urandom_range(0, 29) == 0)
        col_len = $urandom_range(DEPTH - 1, DEPTH + 6);
      else
        col_len = $urandom_range(1, 12);
      mode = column_mode_t'($urandom_range(0, 3));
      base = SAMPLE_W'($urandom);
      for (int k = 0; k < col_len; k++) begin
        case (mode)
          COL_WIDE:   s = SAMPLE_W'($urandom);
          COL_NARROW: s = base + SAMPLE_W'($urandom_range(0, 15));
          COL_FLAT:   s = base;
          default: begin
            if ($urandom_range(0, 3) == 0) s = SAMPLE_W'($urandom);
            else s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          end
        endcase
        push_sample(s, k == col_len - 1);
      end
      random_items += (col_len < DEPTH) ? col_len : DEPTH;
      col_idx++;
    end
    beats_total = pending_samples.size();

    // Wait for every beat to be taken and every result to come back
    do @(negedge clk);
    while (beats_taken != beats_total || scaled_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d sample beats in %0d columns, %0d of them past the buffer depth,",
             beats_taken, columns_done, overfull_columns);
    $display("with %0d scaled beats checked and %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #30ms;
    $display("Timeout: %0d of %0d beats taken, %0d results outstanding",
             beats_taken, beats_total, scaled_due_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
